// ===== rtl/pdr_pkg.sv =====
package pdr_pkg;

  localparam int CordicMax = 30;
  localparam int CordicIterDefault = 16;
  localparam logic [31:0] InvGain = 32'd652032874;
  localparam logic [63:0] HeadK = 64'd12025407501443285;
  localparam logic [33:0] StepCap = 34'h200000000;
  // ceil(2^74 / 10^6), exact quotient for dividends below 2^53
  localparam logic [63:0] UsRecip = 64'd18889465931478581;
  // smallest dividend whose quotient by 10^6 reaches the step cap
  localparam logic [53:0] CapDividend = 54'd8589934592000000;

  localparam logic [1:0] RegInitX = 2'd0;
  localparam logic [1:0] RegInitY = 2'd1;
  localparam logic [1:0] RegInitHeading = 2'd2;

  typedef struct packed {
    logic [47:0] stamp_us;
    logic signed [23:0] speed;
    logic signed [23:0] yaw_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [31:0] out_heading;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_z;
  } out_item_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0: atan_entry = 32'd536870912;
      5'd1: atan_entry = 32'd316933406;
      5'd2: atan_entry = 32'd167458907;
      5'd3: atan_entry = 32'd85004756;
      5'd4: atan_entry = 32'd42667331;
      5'd5: atan_entry = 32'd21354465;
      5'd6: atan_entry = 32'd10679838;
      5'd7: atan_entry = 32'd5340245;
      5'd8: atan_entry = 32'd2670163;
      5'd9: atan_entry = 32'd1335087;
      5'd10: atan_entry = 32'd667544;
      5'd11: atan_entry = 32'd333772;
      5'd12: atan_entry = 32'd166886;
      5'd13: atan_entry = 32'd83443;
      5'd14: atan_entry = 32'd41722;
      5'd15: atan_entry = 32'd20861;
      5'd16: atan_entry = 32'd10430;
      5'd17: atan_entry = 32'd5215;
      5'd18: atan_entry = 32'd2608;
      5'd19: atan_entry = 32'd1304;
      5'd20: atan_entry = 32'd652;
      5'd21: atan_entry = 32'd326;
      5'd22: atan_entry = 32'd163;
      5'd23: atan_entry = 32'd81;
      5'd24: atan_entry = 32'd41;
      5'd25: atan_entry = 32'd20;
      5'd26: atan_entry = 32'd10;
      5'd27: atan_entry = 32'd5;
      5'd28: atan_entry = 32'd3;
      5'd29: atan_entry = 32'd1;
      default: atan_entry = 32'd0;
    endcase
  endfunction

endpackage

// ===== rtl/planar_dead_reckoning_integrator.sv =====
// Unicycle odometry integrator. Each sample with a running stamp goes through a
// fixed sequence on one shared CORDIC rotator and one shared 32x32 multiplier:
// two CORDIC runs, partial products and reciprocal multiplies by 1/10^6 for the
// two position steps, the heading step and a final step to present the result.
// Ready stays low until the result transfer, so the next sample can transfer in
// the cycle after it. A sample while the stored stamp is zero only loads the pose
// from the start_* registers and records the stamp, with no result. The quaternion
// may carry a flipped common sign when the heading wraps.
module planar_dead_reckoning_integrator #(
  parameter int CORDIC_ITERATIONS = pdr_pkg::CordicIterDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  pdr_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output pdr_pkg::out_item_t out_data,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CS1   = 12'b000000000010,
    S_MULH  = 12'b000000000100,
    S_PROD  = 12'b000000001000,
    S_DIV   = 12'b000000010000,
    S_APPLY = 12'b000000100000,
    S_CS2   = 12'b000001000000,
    S_OUT   = 12'b000010000000,
    S_VC    = 12'b000100000000,
    S_DTW   = 12'b001000000000,
    S_HK    = 12'b010000000000,
    S_HEAD  = 12'b100000000000
  } state_t;

  state_t state;
  logic [31:0] start_x, start_y, start_heading;
  logic signed [31:0] est_x, est_y;
  logic [31:0] est_heading;
  logic [47:0] prev_stamp;
  logic [47:0] dtm;
  logic dneg, vneg, wneg;
  logic [23:0] av, aw;
  logic axis;                 // 0 = x, 1 = y
  logic signed [31:0] cs_s;
  logic [31:0] mag_c;
  logic cneg;
  logic [3:0] pstep;
  logic [127:0] acc;
  logic [55:0] vc;            // |v|*|c|
  logic [52:0] nq;            // dividend of the division by 10^6
  logic ovf;
  logic [63:0] hacc;

  logic cs_start, cs_done;
  logic [31:0] cs_angle;
  logic signed [31:0] cs_cos, cs_sin;
  logic [31:0] ma, mb;
  logic [63:0] mp;

  pdr_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk, .rst, .start(cs_start), .angle(cs_angle), .done(cs_done),
    .cos_out(cs_cos), .sin_out(cs_sin)
  );

  pdr_mul u_mul (.clk, .a(ma), .b(mb), .p(mp));

  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[3:2])
      pdr_pkg::RegInitX: prdata = start_x;
      pdr_pkg::RegInitY: prdata = start_y;
      pdr_pkg::RegInitHeading: prdata = start_heading;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      start_heading <= '0;
    end else if (wr && paddr[1:0] == 2'd0) begin
      case (paddr[3:2])
        pdr_pkg::RegInitX: start_x <= pwdata;
        pdr_pkg::RegInitY: start_y <= pwdata;
        pdr_pkg::RegInitHeading: start_heading <= pwdata;
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  // product |dt|*(|v||c|) as 48x56: partial products of 32-bit pieces
  // pieces: dt = {d1[15:0], d0[31:0]}, vc = {e1[23:0], e0[31:0]}
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_VC: begin
        ma = {8'd0, av};
        mb = mag_c;
      end
      S_MULH: begin
        case (pstep[1:0])
          2'd0: begin ma = dtm[31:0]; mb = vc[31:0]; end
          2'd1: begin ma = dtm[31:0]; mb = {8'd0, vc[55:32]}; end
          2'd2: begin ma = {16'd0, dtm[47:32]}; mb = vc[31:0]; end
          default: begin ma = {16'd0, dtm[47:32]}; mb = {8'd0, vc[55:32]}; end
        endcase
      end
      S_DIV: begin
        // quotient by 10^6 as a multiply by the scaled reciprocal
        case (pstep[1:0])
          2'd0: begin ma = nq[31:0]; mb = pdr_pkg::UsRecip[31:0]; end
          2'd1: begin ma = nq[31:0]; mb = pdr_pkg::UsRecip[63:32]; end
          2'd2: begin ma = {11'd0, nq[52:32]}; mb = pdr_pkg::UsRecip[31:0]; end
          default: begin ma = {11'd0, nq[52:32]}; mb = pdr_pkg::UsRecip[63:32]; end
        endcase
      end
      S_DTW: begin
        ma = pstep[0] ? {16'd0, dtm[47:32]} : dtm[31:0];
        mb = {8'd0, aw};
      end
      S_HK: begin
        // hacc holds the low 64 bits of |dt|*|w|
        case (pstep[1:0])
          2'd0: begin ma = hacc[31:0]; mb = pdr_pkg::HeadK[31:0]; end
          2'd1: begin ma = hacc[31:0]; mb = pdr_pkg::HeadK[63:32]; end
          2'd2: begin ma = hacc[63:32]; mb = pdr_pkg::HeadK[31:0]; end
          default: begin ma = hacc[63:32]; mb = pdr_pkg::HeadK[63:32]; end
        endcase
      end
      default: ;
    endcase
  end

  logic [47:0] d;
  logic [33:0] mstep;
  logic signed [31:0] pos_old;
  logic signed [35:0] rsum;
  logic pneg;
  logic [31:0] nh;

  assign d = in_data.stamp_us - prev_stamp;
  assign mstep = ovf ? pdr_pkg::StepCap : {1'b0, acc[106:74]};
  assign pneg = dneg ^ vneg ^ cneg;
  assign pos_old = axis ? est_y : est_x;
  assign rsum = pneg ? 36'(pos_old) - $signed({2'b00, mstep})
                     : 36'(pos_old) + $signed({2'b00, mstep});
  // heading step: (|dt||w|) * K >> 64, round half up; dtw is < 2^71
  // hacc stores dtw[63:0]; dtw_hi stores bits [70:64]
  logic [6:0] dtw_hi;
  assign nh = (dneg ^ wneg) ? est_heading - (32'(dtw_hi) * pdr_pkg::HeadK[31:0] +
                                          acc[95:64] + 32'(acc[63]))
                            : est_heading + (32'(dtw_hi) * pdr_pkg::HeadK[31:0] +
                                          acc[95:64] + 32'(acc[63]));

  always_ff @(posedge clk) begin
    if (rst) begin
      cs_start <= 1'b0;
    end else begin
      cs_start <= (state == S_IDLE && in_valid && in_ready && prev_stamp != '0) ||
                  (state == S_HEAD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prev_stamp <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            prev_stamp <= in_data.stamp_us;
            if (prev_stamp == '0) begin
              est_x <= start_x;
              est_y <= start_y;
              est_heading <= start_heading;
            end else begin
              dneg <= d[47];
              dtm <= d[47] ? -d : d;
              vneg <= in_data.speed[23];
              av <= in_data.speed[23] ? -in_data.speed : in_data.speed;
              wneg <= in_data.yaw_rate[23];
              aw <= in_data.yaw_rate[23] ? -in_data.yaw_rate : in_data.yaw_rate;
              cs_angle <= est_heading;
              state <= S_CS1;
            end
          end
        end
        S_CS1: begin
          if (cs_done) begin
            cs_s <= cs_sin;
            axis <= 1'b0;
            cneg <= cs_cos[31];
            mag_c <= cs_cos[31] ? -cs_cos : cs_cos;
            pstep <= '0;
            state <= S_VC;
          end
        end
        S_VC: begin
          // multiplier output is registered and lands in the cycle after its operands
          if (pstep == 4'd1) begin
            vc <= mp[55:0];
            pstep <= '0;
            acc <= '0;
            state <= S_MULH;
          end else begin
            pstep <= pstep + 4'd1;
          end
        end
        S_MULH: begin
          pstep <= pstep + 4'd1;
          if (pstep != 4'd0) begin
            case (pstep[2:0] - 3'd1)
              3'd0: acc <= acc + 128'(mp);
              3'd1: acc <= acc + (128'(mp) << 32);
              3'd2: acc <= acc + (128'(mp) << 32);
              default: acc <= acc + (128'(mp) << 64);
            endcase
          end
          if (pstep == 4'd4) state <= S_PROD;
        end
        S_PROD: begin
          // dividend is product >> 30; at or above the cap dividend the step is capped
          ovf <= acc[127:30] >= 98'(pdr_pkg::CapDividend);
          nq <= acc[82:30];
          acc <= '0;
          pstep <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          pstep <= pstep + 4'd1;
          if (pstep != 4'd0) begin
            case (pstep[2:0] - 3'd1)
              3'd0: acc <= acc + 128'(mp);
              3'd1: acc <= acc + (128'(mp) << 32);
              3'd2: acc <= acc + (128'(mp) << 32);
              default: acc <= acc + (128'(mp) << 64);
            endcase
          end
          if (pstep == 4'd4) state <= S_APPLY;
        end
        S_APPLY: begin
          if (rsum > 36'sd2147483647) begin
            if (axis) est_y <= 32'sh7fffffff; else est_x <= 32'sh7fffffff;
          end else if (rsum < -36'sd2147483648) begin
            if (axis) est_y <= 32'sh80000000; else est_x <= 32'sh80000000;
          end else begin
            if (axis) est_y <= 32'(rsum); else est_x <= 32'(rsum);
          end
          pstep <= '0;
          if (!axis) begin
            axis <= 1'b1;
            cneg <= cs_s[31];
            mag_c <= cs_s[31] ? -cs_s : cs_s;
            state <= S_VC;
          end else begin
            hacc <= '0;
            state <= S_DTW;
          end
        end
        S_DTW: begin
          if (pstep == 4'd2) begin
            {dtw_hi, hacc} <= {7'd0, hacc} + ({mp[38:0], 32'd0});
            acc <= '0;
            pstep <= '0;
            state <= S_HK;
          end else begin
            pstep <= pstep + 4'd1;
            if (pstep == 4'd1) hacc <= mp;
          end
        end
        S_HK: begin
          pstep <= pstep + 4'd1;
          if (pstep != 4'd0) begin
            case (pstep[2:0] - 3'd1)
              3'd0: acc <= acc + 128'(mp);
              3'd1: acc <= acc + (128'(mp) << 32);
              3'd2: acc <= acc + (128'(mp) << 32);
              default: acc <= acc + (128'(mp) << 64);
            endcase
          end
          if (pstep == 4'd4) state <= S_HEAD;
        end
        S_HEAD: begin
          est_heading <= nh;
          cs_angle <= {1'b0, nh[31:1]};
          state <= S_CS2;
        end
        S_CS2: begin
          if (cs_done) begin
            out_data.quat_w <= cs_cos;
            out_data.quat_z <= cs_sin;
            out_data.out_x <= est_x;
            out_data.out_y <= est_y;
            out_data.out_heading <= est_heading;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT)) else $error("stray result");
  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.quat_w <= 32'sd1073741824 &&
                   out_data.quat_w >= -32'sd1073741824)) else $error("quat range");
`endif

endmodule

// ===== rtl/pdr_cordic.sv =====
module pdr_cordic #(
  parameter int CORDIC_ITERATIONS = pdr_pkg::CordicIterDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [31:0] angle,
  output logic done,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out
);

  logic signed [33:0] x, y, z;
  logic neg, busy;
  logic [4:0] iter;
  logic signed [33:0] xs, ys, fx, fy;
  logic signed [32:0] za;

  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign za = {angle[31], angle};
  assign fx = neg ? -x : x;
  assign fy = neg ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        x <= 34'(pdr_pkg::InvGain);
        y <= '0;
        // fold into the right half plane
        if (za > 33'sd1073741824) begin
          z <= 34'(za) - 34'sd2147483648;
          neg <= 1'b1;
        end else if (za < -33'sd1073741824) begin
          z <= 34'(za) + 34'sd2147483648;
          neg <= 1'b1;
        end else begin
          z <= 34'(za);
          neg <= 1'b0;
        end
      end else if (busy) begin
        if (32'(iter) == CORDIC_ITERATIONS) begin
          busy <= 1'b0;
          done <= 1'b1;
          cos_out <= (fx > 34'sd1073741824) ? 32'sd1073741824 :
                     (fx < -34'sd1073741824) ? -32'sd1073741824 : 32'(fx);
          sin_out <= (fy > 34'sd1073741824) ? 32'sd1073741824 :
                     (fy < -34'sd1073741824) ? -32'sd1073741824 : 32'(fy);
        end else begin
          iter <= iter + 5'd1;
          if (!z[33]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - 34'(pdr_pkg::atan_entry(iter));
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + 34'(pdr_pkg::atan_entry(iter));
          end
        end
      end
    end
  end

endmodule

// ===== rtl/pdr_mul.sv =====
// 32x32 unsigned multiplier, registered product
module pdr_mul (
  input  logic clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule
